// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants and types of the sensor frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] HDR_SYNC0   = 8'hA5;
  localparam logic [7:0] HDR_SYNC1   = 8'h5A;
  localparam int         MAX_PAYLOAD = 100;
  localparam int         STORE_DEPTH = 30;

  localparam int         LIMIT_W     = 31;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd220;

  localparam int         COUNT_W     = 32;
  localparam int         SUM_W       = 48;

  // payload byte offsets of the fields
  localparam int OFS_LEFT    = 0;
  localparam int OFS_RIGHT   = 4;
  localparam int OFS_BATTERY = 8;
  localparam int OFS_ACCEL_X = 12;
  localparam int OFS_ACCEL_Y = 14;
  localparam int OFS_ACCEL_Z = 16;
  localparam int OFS_GYRO_Z  = 22;
  localparam int OFS_MAG_X   = 24;
  localparam int OFS_MAG_Y   = 26;

  // raw fields of one completed frame
  typedef struct packed {
    logic [COUNT_W-1:0] left_raw;
    logic [COUNT_W-1:0] right_raw;
    logic [31:0]        battery_word;
    logic [15:0]        accel_x;
    logic [15:0]        accel_y;
    logic [15:0]        accel_z;
    logic [15:0]        gyro_z;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
  } frame_t;

  // one result transaction
  typedef struct packed {
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;
    logic [31:0]               battery_word;
    logic signed [15:0]        accel_x;
    logic signed [15:0]        accel_y;
    logic signed [15:0]        accel_z;
    logic signed [15:0]        gyro_z;
    logic signed [15:0]        mag_x;
    logic signed [15:0]        mag_y;
    logic signed [SUM_W-1:0]   left_total;
    logic signed [SUM_W-1:0]   right_total;
  } result_t;

endpackage

// ===== rtl/sfd_if.sv =====
// ----------------------------------------------------------------------------
// sfd_if
// valid/ready channels of the sensor frame deframer
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic [31:0]        battery_word;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [47:0] left_total;
  logic signed [47:0] right_total;

  modport source (output valid, output left_count, output right_count,
                  output battery_word, output accel_x, output accel_y,
                  output accel_z, output gyro_z, output mag_x, output mag_y,
                  output left_total, output right_total, input ready);
  modport sink   (input valid, input left_count, input right_count,
                  input battery_word, input accel_x, input accel_y,
                  input accel_z, input gyro_z, input mag_x, input mag_y,
                  input left_total, input right_total, output ready);
endinterface

// ===== rtl/sensor_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_deframer_top
// byte stream deframer for sync-header, length-prefixed sensor frames
// ----------------------------------------------------------------------------
// throughput: one byte transaction per cycle; while a result waits, bytes
//   keep flowing until the next frame closes and fills the frame register
// order: the last payload byte fills the frame register, then the result
//   register, which loads once the receiver has taken the previous result
// reset: rst is synchronous; it clears history, frame state, totals and
//   the valid flags, and sets encoder_limit to 220
// ----------------------------------------------------------------------------
module sensor_frame_deframer_top import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sfd_byte_if.sink           in_ch,
  sfd_result_if.source       out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  // encoder limit register; the user must write it only while the block is idle, the block does not enforce this
  logic [LIMIT_W-1:0] encoder_limit;

  // hand-off between the parser frame register and the result stage
  logic    frame_valid;
  frame_t  frame;
  logic    take;
  logic    accept;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      encoder_limit <= cfg_data;
    end
  end

  // a byte can enter whenever the frame register is empty or drains this
  // cycle; only bytes that close a frame ever fill it
  assign in_ch.ready = !frame_valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  // stage 1: header search, payload capture, field unpacking
  sfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (in_ch.rx_byte),
    .take        (take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  // stage 2: limit check, saturating totals, result register
  sfd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .limit       (encoder_limit),
    .frame_valid (frame_valid),
    .frame       (frame),
    .out_ready   (out_ch.ready),
    .take        (take),
    .out_valid   (out_ch.valid),
    .result      (result)
  );

  // result transaction fields
  assign out_ch.left_count   = result.left_count;
  assign out_ch.right_count  = result.right_count;
  assign out_ch.battery_word = result.battery_word;
  assign out_ch.accel_x      = result.accel_x;
  assign out_ch.accel_y      = result.accel_y;
  assign out_ch.accel_z      = result.accel_z;
  assign out_ch.gyro_z       = result.gyro_z;
  assign out_ch.mag_x        = result.mag_x;
  assign out_ch.mag_y        = result.mag_y;
  assign out_ch.left_total   = result.left_total;
  assign out_ch.right_total  = result.right_total;

endmodule

// ===== rtl/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser
// header search, payload capture and field unpacking, one byte per cycle while accept is high
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       frame_valid,
  output frame_t     frame
);

  logic [7:0] hist [3];
  logic       in_frame;
  logic [7:0] frame_length;
  logic [7:0] byte_count;
  logic [7:0] store [STORE_DEPTH];

  logic [7:0] hist_next [3];
  logic       in_frame_next;
  logic [7:0] frame_length_next;
  logic [7:0] byte_count_next;
  logic [7:0] store_next [STORE_DEPTH];
  logic [7:0] store_wr [STORE_DEPTH];

  logic       hdr;
  logic       act_frame;
  logic [7:0] act_len;
  logic [7:0] act_cnt;
  logic [7:0] cnt_inc;
  logic       done;
  frame_t     frame_next;

  // hist[2] is oldest, hist[0] the newest byte
  assign hdr = (hist[2] == HDR_SYNC0) && (hist[1] == HDR_SYNC1) &&
               (hist[0] != 8'd0) && (hist[0] <= 8'(MAX_PAYLOAD));

  assign act_frame = hdr || in_frame;
  assign act_len   = hdr ? hist[0] : frame_length;
  assign act_cnt   = hdr ? 8'd0 : byte_count;
  assign cnt_inc   = act_cnt + 8'd1;
  assign done      = act_frame && (cnt_inc == act_len);

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_wr[i] = hdr ? 8'd0 : store[i];
      if (act_frame && (act_cnt == 8'(i))) begin
        store_wr[i] = rx_byte;
      end
    end
  end

  always_comb begin
    frame_next.left_raw     = {store_wr[OFS_LEFT+3], store_wr[OFS_LEFT+2],
                               store_wr[OFS_LEFT+1], store_wr[OFS_LEFT]};
    frame_next.right_raw    = {store_wr[OFS_RIGHT+3], store_wr[OFS_RIGHT+2],
                               store_wr[OFS_RIGHT+1], store_wr[OFS_RIGHT]};
    frame_next.battery_word = {store_wr[OFS_BATTERY+3], store_wr[OFS_BATTERY+2],
                               store_wr[OFS_BATTERY+1], store_wr[OFS_BATTERY]};
    frame_next.accel_x      = {store_wr[OFS_ACCEL_X+1], store_wr[OFS_ACCEL_X]};
    frame_next.accel_y      = {store_wr[OFS_ACCEL_Y+1], store_wr[OFS_ACCEL_Y]};
    frame_next.accel_z      = {store_wr[OFS_ACCEL_Z+1], store_wr[OFS_ACCEL_Z]};
    frame_next.gyro_z       = {store_wr[OFS_GYRO_Z+1], store_wr[OFS_GYRO_Z]};
    frame_next.mag_x        = {store_wr[OFS_MAG_X+1], store_wr[OFS_MAG_X]};
    frame_next.mag_y        = {store_wr[OFS_MAG_Y+1], store_wr[OFS_MAG_Y]};
  end

  always_comb begin
    if (done) begin
      // frame end clears everything, the closing byte stays out of the history
      in_frame_next     = 1'b0;
      frame_length_next = 8'd0;
      byte_count_next   = 8'd0;
      for (int i = 0; i < 3; i++) begin
        hist_next[i] = 8'd0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_next[i] = 8'd0;
      end
    end else begin
      in_frame_next     = act_frame;
      frame_length_next = act_len;
      byte_count_next   = act_frame ? cnt_inc : byte_count;
      hist_next[2]      = hist[1];
      hist_next[1]      = hist[0];
      hist_next[0]      = rx_byte;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_next[i] = store_wr[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      frame_length <= 8'd0;
      byte_count   <= 8'd0;
      for (int i = 0; i < 3; i++) begin
        hist[i] <= 8'd0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= 8'd0;
      end
    end else if (accept) begin
      in_frame     <= in_frame_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      hist         <= hist_next;
      store        <= store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && done) begin
      frame_valid <= 1'b1;
    end else if (take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      frame <= frame_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> !in_frame && (byte_count == 8'd0) && (hist[0] == 8'd0))
    else $error("frame end did not clear parser state");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_count < frame_length) && (frame_length != 8'd0))
    else $error("byte count ran past frame length");

  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !take |=> frame_valid && $stable(frame))
    else $error("pending frame lost before hand-off");

endmodule

// ===== rtl/sfd_accum.sv =====
// ----------------------------------------------------------------------------
// sfd_accum
// encoder limit check, saturating running totals and result register
// ----------------------------------------------------------------------------
module sfd_accum import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               frame_valid,
  input  frame_t             frame,
  input  logic               out_ready,
  output logic               take,
  output logic               out_valid,
  output result_t            result
);

  logic signed [SUM_W-1:0]   left_sum;
  logic signed [SUM_W-1:0]   right_sum;
  logic signed [SUM_W-1:0]   left_sum_next;
  logic signed [SUM_W-1:0]   right_sum_next;
  logic signed [COUNT_W-1:0] left_cnt;
  logic signed [COUNT_W-1:0] right_cnt;
  result_t                   result_next;

  function automatic logic signed [COUNT_W-1:0] clip_count(
    input logic [COUNT_W-1:0] raw,
    input logic [LIMIT_W-1:0] lim
  );
    logic signed [COUNT_W:0] c;
    logic signed [COUNT_W:0] hi;
    logic signed [COUNT_W:0] lo;
    c  = $signed({raw[COUNT_W-1], raw});
    hi = $signed({2'b00, lim});
    lo = -hi;
    clip_count = ((c > hi) || (c < lo)) ? '0 : $signed(raw);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   acc,
    input logic signed [COUNT_W-1:0] cnt
  );
    logic signed [SUM_W:0] s;
    s = $signed({acc[SUM_W-1], acc}) +
        $signed({{(SUM_W+1-COUNT_W){cnt[COUNT_W-1]}}, cnt});
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  assign take = frame_valid && (!out_valid || out_ready);

  assign left_cnt       = clip_count(frame.left_raw, limit);
  assign right_cnt      = clip_count(frame.right_raw, limit);
  assign left_sum_next  = sat_add(left_sum, left_cnt);
  assign right_sum_next = sat_add(right_sum, right_cnt);

  always_comb begin
    result_next.left_count   = left_cnt;
    result_next.right_count  = right_cnt;
    result_next.battery_word = frame.battery_word;
    result_next.accel_x      = $signed(frame.accel_x);
    result_next.accel_y      = $signed(frame.accel_y);
    result_next.accel_z      = $signed(frame.accel_z);
    result_next.gyro_z       = $signed(frame.gyro_z);
    result_next.mag_x        = $signed(frame.mag_x);
    result_next.mag_y        = $signed(frame.mag_y);
    result_next.left_total   = left_sum_next;
    result_next.right_total  = right_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left_sum  <= '0;
      right_sum <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      left_sum  <= left_sum_next;
      right_sum <= right_sum_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && (result.left_total == left_sum) &&
             (result.right_total == right_sum))
    else $error("result totals differ from running sums");

  a_left_within_limit: assert property (@(posedge clk) disable iff (rst)
    take |=> ($signed({result.left_count[COUNT_W-1], result.left_count}) <=
              $signed({2'b00, $past(limit)})) &&
             ($signed({result.left_count[COUNT_W-1], result.left_count}) >=
              -$signed({2'b00, $past(limit)})))
    else $error("left count escaped the limit check");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !take)
    else $error("result overwritten while stalled");

endmodule

// ===== tb/sv/sfd_frame_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfd_frame_check
// Watches the byte and result channels of the sensor frame deframer. It
// tracks the sync header, payload and running totals byte by byte, queues
// the frame it expects and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module sfd_frame_check import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sfd_byte_if                byte_ch,
  sfd_result_if              result_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int unsigned        awaiting,
  output int unsigned        fail_count
);

  localparam longint TOTAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 1;

  // shadow of the deframer state
  logic [7:0]         recent [3];
  bit                 framing;
  logic [7:0]         frame_len;
  logic [7:0]         byte_cnt;
  logic [7:0]         payload [STORE_DEPTH];
  longint             left_acc;
  longint             right_acc;
  logic [LIMIT_W-1:0] limit_val;

  result_t decoded_frames [$];

  function automatic void clear_frame_state();
    foreach (recent[i]) recent[i] = '0;
    foreach (payload[i]) payload[i] = '0;
    framing   = 1'b0;
    frame_len = '0;
    byte_cnt  = '0;
  endfunction

  function automatic logic [31:0] le32(input int ofs);
    return {payload[ofs+3], payload[ofs+2], payload[ofs+1], payload[ofs]};
  endfunction

  function automatic logic [15:0] le16(input int ofs);
    return {payload[ofs+1], payload[ofs]};
  endfunction

  // counts outside +-limit read as zero
  function automatic longint clip_count(input logic [31:0] raw);
    longint c;
    longint lim;
    c   = $signed(raw);
    lim = limit_val;
    return (c > lim || c < -lim) ? 0 : c;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > TOTAL_MAX) return TOTAL_MAX;
    if (s < TOTAL_MIN) return TOTAL_MIN;
    return s;
  endfunction

  // one received byte; returns 1 when it completes a frame
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    longint lc;
    longint rc;
    r = '0;
    if (recent[2] == HDR_SYNC0 && recent[1] == HDR_SYNC1 &&
        recent[0] != 8'd0 && recent[0] <= MAX_PAYLOAD) begin
      framing   = 1'b1;
      frame_len = recent[0];
      byte_cnt  = '0;
      foreach (payload[i]) payload[i] = '0;
    end
    if (framing) begin
      if (byte_cnt < STORE_DEPTH) payload[byte_cnt] = b;
      byte_cnt = byte_cnt + 8'd1;
      if (byte_cnt == frame_len) begin
        lc        = clip_count(le32(OFS_LEFT));
        rc        = clip_count(le32(OFS_RIGHT));
        left_acc  = sat_sum(left_acc, lc);
        right_acc = sat_sum(right_acc, rc);
        r.left_count   = lc[31:0];
        r.right_count  = rc[31:0];
        r.battery_word = le32(OFS_BATTERY);
        r.accel_x      = le16(OFS_ACCEL_X);
        r.accel_y      = le16(OFS_ACCEL_Y);
        r.accel_z      = le16(OFS_ACCEL_Z);
        r.gyro_z       = le16(OFS_GYRO_Z);
        r.mag_x        = le16(OFS_MAG_X);
        r.mag_y        = le16(OFS_MAG_Y);
        r.left_total   = left_acc[SUM_W-1:0];
        r.right_total  = right_acc[SUM_W-1:0];
        clear_frame_state();
        return 1'b1;
      end
    end
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = b;
    return 1'b0;
  endfunction

  // report every failure and count it
  task automatic note_failure(input string what);
    $error("%s", what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got)
      note_failure($sformatf("%s: expected %0d, actual %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t fresh;
    if (rst) begin
      clear_frame_state();
      left_acc   = 0;
      right_acc  = 0;
      limit_val  = LIMIT_RESET;
      fail_count = 0;
      decoded_frames.delete();
    end else begin
      if (cfg_we) limit_val = cfg_data;
      if (result_ch.valid && result_ch.ready) begin
        seen.left_count   = result_ch.left_count;
        seen.right_count  = result_ch.right_count;
        seen.battery_word = result_ch.battery_word;
        seen.accel_x      = result_ch.accel_x;
        seen.accel_y      = result_ch.accel_y;
        seen.accel_z      = result_ch.accel_z;
        seen.gyro_z       = result_ch.gyro_z;
        seen.mag_x        = result_ch.mag_x;
        seen.mag_y        = result_ch.mag_y;
        seen.left_total   = result_ch.left_total;
        seen.right_total  = result_ch.right_total;
        if ($isunknown(seen))
          note_failure($sformatf("result with unknown bits: %h", seen));
        if (decoded_frames.size() == 0) begin
          note_failure("result transaction with no frame pending");
        end else begin
          want = decoded_frames.pop_front();
          check_field("left_count",   want.left_count,   seen.left_count);
          check_field("right_count",  want.right_count,  seen.right_count);
          check_field("battery_word", want.battery_word, seen.battery_word);
          check_field("accel_x",      want.accel_x,      seen.accel_x);
          check_field("accel_y",      want.accel_y,      seen.accel_y);
          check_field("accel_z",      want.accel_z,      seen.accel_z);
          check_field("gyro_z",       want.gyro_z,       seen.gyro_z);
          check_field("mag_x",        want.mag_x,        seen.mag_x);
          check_field("mag_y",        want.mag_y,        seen.mag_y);
          check_field("left_total",   want.left_total,   seen.left_total);
          check_field("right_total",  want.right_total,  seen.right_total);
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        if (decode_byte(byte_ch.rx_byte, fresh)) decoded_frames.push_back(fresh);
    end
    awaiting = decoded_frames.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream test of the sensor frame deframer. A short opening sequence
// hits bad lengths, a short payload and a header inside a payload; random
// frames, broken frames and noise then run under several encoder limits,
// the smallest and largest included.
// The frame check module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  typedef enum int {RX_STEADY, RX_SPOTTY, RX_LONG_STALLS, RX_ALTERNATE} rx_mode_e;

  // bad length, bad length, short frame of four bytes, then a restarted frame
  localparam logic [7:0] OPENING_BYTES [22] = '{
    HDR_SYNC0, HDR_SYNC1, 8'd0,
    HDR_SYNC0, HDR_SYNC1, 8'(MAX_PAYLOAD + 1),
    HDR_SYNC0, HDR_SYNC1, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    HDR_SYNC0, HDR_SYNC1, 8'd6, 8'h11, HDR_SYNC0, HDR_SYNC1, 8'd2, 8'h22, 8'h33
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  int unsigned        awaiting;
  int unsigned        fail_count;

  sfd_byte_if   byte_ch ();
  sfd_result_if result_ch ();

  // sender and receiver pacing
  bit                 full_rate;
  int                 burst_left;
  int unsigned        bytes_sent;
  logic [LIMIT_W-1:0] limit_now;
  rx_mode_e           rx_mode;
  int                 stall_left;
  logic [31:0]        rx_tick;

  sensor_frame_deframer_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (byte_ch),
    .out_ch   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  sfd_frame_check frame_check (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .result_ch  (result_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .awaiting   (awaiting),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: the stall pattern is picked anew at random whenever the low eight bits of rx_tick reach 8'hFF
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_tick         <= '0;
      rx_mode         <= RX_STEADY;
      stall_left      <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick[7:0] == 8'hFF) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      if (full_rate) begin
        result_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left      <= stall_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY: begin
            result_ch.ready <= 1'b1;
          end
          RX_SPOTTY: begin
            result_ch.ready <= ($urandom_range(0, 2) != 0);
          end
          RX_LONG_STALLS: begin
            if ($urandom_range(0, 15) == 0) begin
              stall_left      <= $urandom_range(5, 40);
              result_ch.ready <= 1'b0;
            end else begin
              result_ch.ready <= 1'b1;
            end
          end
          default: begin
            result_ch.ready <= rx_tick[0];
          end
        endcase
      end
    end
  end

  // one byte transaction; between bursts the sender may go quiet for a while
  task automatic push_byte(input logic [7:0] value);
    int gap;
    if (!full_rate && burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      // now and then a long burst with no gaps at all
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= value;
    do @(posedge clk); while (!byte_ch.ready);
    burst_left--;
    bytes_sent++;
  endtask

  // wait until every expected frame has come out, plus the pipeline depth
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
  endtask

  // encoder count near the interesting edges of the current limit
  function automatic logic [31:0] pick_count();
    longint      lim;
    int unsigned span;
    logic [31:0] c;
    lim  = limit_now;
    span = {limit_now, 1'b0};
    case ($urandom_range(0, 7))
      0:       c = 32'(longint'($urandom_range(0, span)) - lim);
      1:       c = 32'(lim);
      2:       c = 32'(-lim);
      3:       c = 32'(lim + 1);
      4:       c = 32'(-lim - 1);
      5:       c = 32'h8000_0000;
      6:       c = 32'h7FFF_FFFF;
      default: c = $urandom;
    endcase
    return c;
  endfunction

  task automatic send_frame(input int len, input logic [31:0] lc, input logic [31:0] rc);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i < 4) push_byte(lc[8*i +: 8]);
      else if (i < 8) push_byte(rc[8*(i-4) +: 8]);
      else push_byte(8'($urandom));
    end
  endtask

  // mostly clean frames, the rest noise, cut-off frames and bad headers
  task automatic random_phase(input int unsigned budget);
    int unsigned start;
    int          roll;
    int          len;
    int          cut;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) len = $urandom_range(28, STORE_DEPTH);
        else if (roll < 70) len = $urandom_range(8, 27);
        else if (roll < 80) len = $urandom_range(1, 7);
        else if (roll < 90) len = $urandom_range(STORE_DEPTH + 1, MAX_PAYLOAD);
        else len = MAX_PAYLOAD;
        send_frame(len, pick_count(), pick_count());
      end else if (roll < 82) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else if (roll < 92) begin
        // header and part of the payload; what follows restarts or extends it
        len = $urandom_range(4, STORE_DEPTH);
        cut = $urandom_range(0, len - 1);
        push_byte(HDR_SYNC0);
        push_byte(HDR_SYNC1);
        push_byte(8'(len));
        repeat (cut) push_byte(8'($urandom));
      end else begin
        push_byte(HDR_SYNC0);
        push_byte(HDR_SYNC1);
        if ($urandom_range(0, 1) == 0) push_byte(8'd0);
        else push_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    full_rate       = 1'b0;
    burst_left      = 0;
    bytes_sent      = 0;
    limit_now       = LIMIT_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // opening sequence under the reset limit
    foreach (OPENING_BYTES[i]) push_byte(OPENING_BYTES[i]);

    // random traffic across several limits, extremes included
    random_phase(160);
    write_limit('0);
    random_phase(160);
    write_limit('1);
    random_phase(160);
    write_limit(LIMIT_W'($urandom));
    random_phase(160);
    write_limit(31'd1000);
    random_phase(160);

    drain();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/sfd_parser.sv
rtl/sfd_accum.sv
rtl/sensor_frame_deframer_top.sv
tb/sv/sfd_frame_check.sv
tb/sv/tb_top.sv
